/* sv/multilinear_table_interpolator_defines.svh */
// Assertion macros for the multilinear table interpolator.
// Included by the modules that assert; expects clk and arst_n in scope.
`ifndef MULTILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH
`define MULTILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define MLTI_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MLTI_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mlti_pkg.sv */
// Shared constants, codes and lane/merge structs for the table interpolator.
// No dependencies.
package mlti_pkg;

	localparam int MAX_DIMS          = 4;
	localparam int MAX_AXIS_POINTS   = 16;
	localparam int MAX_TABLE_ENTRIES = 4096;
	localparam int MAX_COMPONENTS    = 4;
	localparam int LANES             = 4;

	localparam int BP_AW = $clog2(MAX_AXIS_POINTS);
	localparam int NP_W  = $clog2(MAX_AXIS_POINTS + 1);
	localparam int W_W   = 17;
	localparam logic [W_W-1:0] ONE_W = 17'h10000;

	localparam logic [1:0] REQ_BP_WR  = 2'd0;
	localparam logic [1:0] REQ_TBL_WR = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_MONO   = 2'd1;
	localparam logic [1:0] ST_TOOBIG = 2'd2;
	localparam logic [1:0] ST_RANGE  = 2'd3;

	localparam logic [2:0] CFG_DIMS  = 3'd0;
	localparam logic [2:0] CFG_PTS0  = 3'd1;
	localparam logic [2:0] CFG_PTS1  = 3'd2;
	localparam logic [2:0] CFG_PTS2  = 3'd3;
	localparam logic [2:0] CFG_PTS3  = 3'd4;
	localparam logic [2:0] CFG_COMPS = 3'd5;

	typedef struct packed {
		logic               wr;
		logic               qry;
		logic [BP_AW-1:0]   idx;
		logic signed [31:0] value;
		logic signed [31:0] x;
		logic [NP_W-1:0]    np;
	} lane_cmd_t;

	typedef struct packed {
		logic             busy;
		logic             mono_bad;
		logic [BP_AW-1:0] base;
		logic [W_W-1:0]   weight;
	} lane_res_t;

	typedef struct packed {
		logic [2:0]                   nd;
		logic [2:0]                   nc;
		logic [1:0]                   comp;
		logic [LANES-1:0][NP_W-1:0]   np;
		logic [LANES-1:0][BP_AW-1:0]  base;
		logic [LANES-1:0][W_W-1:0]    w;
	} corner_cfg_t;

endpackage

/* sv/mlti_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/mlti_axis_lane.sv */
// One axis lane: breakpoint store, monotonic check, interval search, weight divide.
// Depends on mlti_pkg and mlti_ram.
module mlti_axis_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  mlti_pkg::lane_cmd_t cmd,
	output mlti_pkg::lane_res_t res
);

	typedef enum logic [2:0] {L_IDLE, L_WRD, L_WCMP, L_SRD, L_SUSE, L_PREP, L_DIV} lstate_t;

	lstate_t                         st_q;
	logic [mlti_pkg::BP_AW-1:0]      addr_q, widx_q, base_q;
	logic signed [31:0]              val_q, lo_q, hi_q;
	logic [mlti_pkg::NP_W-1:0]       np_q;
	logic [31:0]                     rem_q, div_q;
	logic [15:0]                     quo_q;
	logic [3:0]                      cnt_q;
	logic [mlti_pkg::W_W-1:0]        w_q;
	logic                            mono_q, chk_q;

	logic [31:0]        rdata;
	logic signed [31:0] rd_s;
	logic signed [32:0] d_w, s_w;
	logic [32:0]        rem2;
	logic               ge, last_i;

	mlti_ram #(.WIDTH(32), .DEPTH(mlti_pkg::MAX_AXIS_POINTS)) u_bp (
		.clk   (clk),
		.we    (st_q == L_WCMP),
		.waddr (widx_q),
		.wdata (val_q),
		.raddr (addr_q),
		.rdata (rdata)
	);

	always_comb begin
		rd_s   = $signed(rdata);
		d_w    = $signed({val_q[31], val_q}) - $signed({lo_q[31], lo_q});
		s_w    = $signed({hi_q[31], hi_q}) - $signed({lo_q[31], lo_q});
		rem2   = {rem_q, 1'b0};
		ge     = rem2 >= {1'b0, div_q};
		last_i = mlti_pkg::NP_W'(addr_q) == (np_q - mlti_pkg::NP_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			mono_q <= 1'b0;
		end else begin
			case (st_q)
				L_IDLE: begin
					if (cmd.wr) begin
						val_q  <= cmd.value;
						widx_q <= cmd.idx;
						addr_q <= cmd.idx - mlti_pkg::BP_AW'(1);
						chk_q  <= cmd.idx != '0;
						st_q   <= (cmd.idx != '0) ? L_WRD : L_WCMP;
					end else if (cmd.qry) begin
						val_q  <= cmd.x;
						np_q   <= cmd.np;
						addr_q <= '0;
						st_q   <= L_SRD;
					end
				end
				L_WRD: st_q <= L_WCMP;
				L_WCMP: begin
					mono_q <= chk_q && (val_q <= rd_s);
					st_q   <= L_IDLE;
				end
				L_SRD: st_q <= L_SUSE;
				L_SUSE: begin
					if (addr_q == '0) begin
						lo_q   <= rd_s;
						addr_q <= mlti_pkg::BP_AW'(1);
						st_q   <= L_SRD;
					end else if ((val_q < rd_s) || last_i) begin
						hi_q   <= rd_s;
						base_q <= addr_q - mlti_pkg::BP_AW'(1);
						st_q   <= L_PREP;
					end else begin
						lo_q   <= rd_s;
						addr_q <= addr_q + mlti_pkg::BP_AW'(1);
						st_q   <= L_SRD;
					end
				end
				L_PREP: begin
					if (s_w <= 0) begin
						w_q  <= (d_w > 0) ? mlti_pkg::ONE_W : '0;
						st_q <= L_IDLE;
					end else if (d_w <= 0) begin
						w_q  <= '0;
						st_q <= L_IDLE;
					end else if (d_w >= s_w) begin
						w_q  <= mlti_pkg::ONE_W;
						st_q <= L_IDLE;
					end else begin
						rem_q <= d_w[31:0];
						div_q <= s_w[31:0];
						quo_q <= '0;
						cnt_q <= 4'd15;
						st_q  <= L_DIV;
					end
				end
				L_DIV: begin
					if (ge)
						rem_q <= 32'(rem2 - {1'b0, div_q});
					else
						rem_q <= rem2[31:0];
					quo_q <= {quo_q[14:0], ge};
					if (cnt_q == '0) begin
						w_q  <= {1'b0, quo_q[14:0], ge};
						st_q <= L_IDLE;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	assign res.busy     = st_q != L_IDLE;
	assign res.mono_bad = mono_q;
	assign res.base     = base_q;
	assign res.weight   = w_q;

endmodule

/* sv/mlti_corner_acc.sv */
// Merge stage: walks the corners, forms weight products, reads values, accumulates.
// Depends on mlti_pkg and the assertion macros header; reads the value RAM held by the top level.
`include "multilinear_table_interpolator_defines.svh"
module mlti_corner_acc #(
	parameter int MAX_TABLE_ENTRIES = mlti_pkg::MAX_TABLE_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  mlti_pkg::corner_cfg_t            cfg,
	output logic [$clog2(MAX_TABLE_ENTRIES)-1:0] raddr,
	input  logic [31:0]                      rdata,
	output logic                             busy,
	output logic signed [31:0]               value
);

	localparam int AW    = $clog2(MAX_TABLE_ENTRIES);
	localparam int FW    = AW + 1;
	localparam int ACC_W = 56;
	localparam int QS_W  = ACC_W - 16;
	localparam logic signed [QS_W-1:0] QMAX = QS_W'(64'sh7FFFFFFF);
	localparam logic signed [QS_W-1:0] QMIN = QS_W'(-64'sh80000000);

	typedef enum logic [2:0] {C_IDLE, C_AX, C_IX, C_RD, C_MUL, C_ACC, C_FIN} cstate_t;

	cstate_t                   st_q;
	logic [3:0]                jb_q;
	logic [1:0]                d_q;
	logic [mlti_pkg::W_W-1:0]  p_q;
	logic [FW-1:0]             flat_q;
	logic [AW-1:0]             addr_q;
	logic                      inr_q;
	logic signed [48:0]        prod_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [31:0]        value_q;

	logic [1:0]                sel;
	logic                      cbit;
	logic [mlti_pkg::W_W-1:0]  wd;
	logic [33:0]               pm;
	logic [FW-1:0]             flat_n, flat_f;
	logic [3:0]                jb_last;
	logic signed [ACC_W-1:0]   t_w;
	logic signed [QS_W-1:0]    qs;

	always_comb begin
		sel     = 2'(cfg.nd - 3'd1 - {1'b0, d_q});
		cbit    = jb_q[sel];
		wd      = cbit ? cfg.w[d_q] : (mlti_pkg::ONE_W - cfg.w[d_q]);
		pm      = 34'(p_q * wd) + 34'd32768;
		flat_n  = FW'(flat_q * cfg.np[d_q]) + FW'(cfg.base[d_q]) + FW'(cbit);
		flat_f  = FW'(flat_q * cfg.nc) + FW'(cfg.comp);
		jb_last = 4'((5'd1 << cfg.nd) - 5'd1);
		t_w     = acc_q + ACC_W'(32768);
		qs      = t_w[ACC_W-1:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
		end else begin
			case (st_q)
				C_IDLE: begin
					if (start) begin
						jb_q   <= '0;
						d_q    <= '0;
						p_q    <= mlti_pkg::ONE_W;
						flat_q <= '0;
						acc_q  <= '0;
						st_q   <= C_AX;
					end
				end
				C_AX: begin
					p_q    <= pm[32:16];
					flat_q <= flat_n;
					if ({1'b0, d_q} == cfg.nd - 3'd1)
						st_q <= C_IX;
					else
						d_q <= d_q + 2'd1;
				end
				C_IX: begin
					addr_q <= flat_f[AW-1:0];
					inr_q  <= flat_f < FW'(MAX_TABLE_ENTRIES);
					st_q   <= C_RD;
				end
				C_RD: st_q <= C_MUL;
				C_MUL: begin
					prod_s1 <= inr_q ? 49'($signed(rdata) * $signed({1'b0, p_q})) : '0;
					st_q    <= C_ACC;
				end
				C_ACC: begin
					acc_q <= acc_q + ACC_W'(prod_s1);
					if (jb_q == jb_last) begin
						st_q <= C_FIN;
					end else begin
						jb_q   <= jb_q + 4'd1;
						d_q    <= '0;
						p_q    <= mlti_pkg::ONE_W;
						flat_q <= '0;
						st_q   <= C_AX;
					end
				end
				C_FIN: begin
					if (qs > QMAX)
						value_q <= 32'sh7FFFFFFF;
					else if (qs < QMIN)
						value_q <= 32'sh80000000;
					else
						value_q <= qs[31:0];
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	assign raddr = addr_q;
	assign busy  = st_q != C_IDLE;
	assign value = value_q;

	`MLTI_AST_NXT(a_start_busy, start && !busy, busy, "corner walk did not start")
	`MLTI_AST_IMP(a_weight_range, st_q == C_MUL, p_q <= mlti_pkg::ONE_W, "weight product above one")
	`MLTI_AST_IMP(a_axis_range, st_q == C_AX, {1'b0, d_q} < cfg.nd, "axis step past dims in use")

endmodule

/* sv/multilinear_table_interpolator.sv */
// Channel  | handshake             | word
// in       | in_valid / in_ready   | req_type, axis_sel, entry_index, write_value, coord_*, component
// out      | out_valid / out_ready | interp_value, status
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
// One item at a time. Table writes and rejected requests go straight to the output stage; a
// breakpoint write waits for its lane's read and monotonic check, and a query runs the axis
// lanes (search reads plus a 16-step divide) and then the corner walk.
// Reset clears control and config only; stores are undefined until written.
// A finished word waits in the output register; the next result then holds in ST_FIN until taken.
`include "multilinear_table_interpolator_defines.svh"
module multilinear_table_interpolator #(
	parameter int MAX_TABLE_ENTRIES = mlti_pkg::MAX_TABLE_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [1:0]         axis_sel,
	input  logic [11:0]        entry_index,
	input  logic signed [31:0] write_value,
	input  logic signed [31:0] coord_0,
	input  logic signed [31:0] coord_1,
	input  logic signed [31:0] coord_2,
	input  logic signed [31:0] coord_3,
	input  logic [1:0]         component,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] interp_value,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	localparam int AW = $clog2(MAX_TABLE_ENTRIES);
	localparam int NP_W = mlti_pkg::NP_W;

	typedef enum logic [2:0] {ST_IDLE, ST_BPW, ST_QLN, ST_QCN, ST_FIN} state_t;

	state_t             st_q;
	logic [2:0]         dims_q, comps_q;
	logic [4:0]         pts_q [mlti_pkg::LANES];
	logic [1:0]         axis_q, comp_q;
	logic signed [31:0] res_value_q, out_value_q;
	logic [1:0]         res_status_q, out_status_q;
	logic               out_valid_q;

	logic                       acc_in;
	logic                       bp_ok, tbl_ok;
	logic [2:0]                 nd, nc;
	logic [NP_W-1:0]            np [mlti_pkg::LANES];
	logic [19:0]                size_w;
	logic signed [31:0]         coord_a [mlti_pkg::LANES];
	mlti_pkg::lane_cmd_t        lcmd [mlti_pkg::LANES];
	mlti_pkg::lane_res_t        lres [mlti_pkg::LANES];
	logic [mlti_pkg::LANES-1:0] lbusy;
	mlti_pkg::corner_cfg_t      ccfg;
	logic                       c_start, c_busy;
	logic signed [31:0]         c_value;
	logic [AW-1:0]              t_raddr;
	logic [31:0]                t_rdata;
	logic                       q_ok;

	assign in_ready  = st_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign acc_in    = in_valid && in_ready;

	always_comb begin
		coord_a[0] = coord_0;
		coord_a[1] = coord_1;
		coord_a[2] = coord_2;
		coord_a[3] = coord_3;
		nd = (dims_q < 3'd1) ? 3'd1 : ((dims_q > 3'd4) ? 3'd4 : dims_q);
		nc = (comps_q < 3'd1) ? 3'd1 :
			((comps_q > 3'(mlti_pkg::MAX_COMPONENTS)) ? 3'(mlti_pkg::MAX_COMPONENTS) : comps_q);
		size_w = 20'(nc);
		for (int l = 0; l < mlti_pkg::LANES; l++) begin
			np[l] = (pts_q[l] < 5'd2) ? NP_W'(2) :
				((pts_q[l] > 5'(mlti_pkg::MAX_AXIS_POINTS)) ? NP_W'(mlti_pkg::MAX_AXIS_POINTS)
				: NP_W'(pts_q[l]));
			if (3'(l) < nd)
				size_w = 20'(size_w * np[l]);
		end
		bp_ok  = (32'(axis_sel) < mlti_pkg::MAX_DIMS) && (32'(entry_index) < mlti_pkg::MAX_AXIS_POINTS);
		tbl_ok = 32'(entry_index) < MAX_TABLE_ENTRIES;
		q_ok   = (32'(size_w) <= MAX_TABLE_ENTRIES) && ({1'b0, component} < nc);
		for (int l = 0; l < mlti_pkg::LANES; l++) begin
			lcmd[l].wr    = acc_in && (req_type == mlti_pkg::REQ_BP_WR) && bp_ok &&
				(axis_sel == 2'(l));
			lcmd[l].qry   = acc_in && (req_type == mlti_pkg::REQ_QUERY) && q_ok && (3'(l) < nd);
			lcmd[l].idx   = entry_index[mlti_pkg::BP_AW-1:0];
			lcmd[l].value = write_value;
			lcmd[l].x     = coord_a[l];
			lcmd[l].np    = np[l];
			lbusy[l]      = lres[l].busy;
			ccfg.np[l]    = np[l];
			ccfg.base[l]  = lres[l].base;
			ccfg.w[l]     = lres[l].weight;
		end
		ccfg.nd   = nd;
		ccfg.nc   = nc;
		ccfg.comp = comp_q;
		c_start   = (st_q == ST_QLN) && (lbusy == '0);
	end

	for (genvar g = 0; g < mlti_pkg::LANES; g++) begin : g_lane
		mlti_axis_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (lcmd[g]),
			.res    (lres[g])
		);
	end

	mlti_ram #(.WIDTH(32), .DEPTH(MAX_TABLE_ENTRIES)) u_tbl (
		.clk   (clk),
		.we    (acc_in && (req_type == mlti_pkg::REQ_TBL_WR) && tbl_ok),
		.waddr (AW'(entry_index)),
		.wdata (write_value),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	mlti_corner_acc #(.MAX_TABLE_ENTRIES(MAX_TABLE_ENTRIES)) u_corner (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (c_start),
		.cfg    (ccfg),
		.raddr  (t_raddr),
		.rdata  (t_rdata),
		.busy   (c_busy),
		.value  (c_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= 3'd1;
			comps_q <= 3'd1;
			for (int l = 0; l < mlti_pkg::LANES; l++)
				pts_q[l] <= 5'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				mlti_pkg::CFG_DIMS:  dims_q   <= cfg_data[2:0];
				mlti_pkg::CFG_PTS0:  pts_q[0] <= cfg_data[4:0];
				mlti_pkg::CFG_PTS1:  pts_q[1] <= cfg_data[4:0];
				mlti_pkg::CFG_PTS2:  pts_q[2] <= cfg_data[4:0];
				mlti_pkg::CFG_PTS3:  pts_q[3] <= cfg_data[4:0];
				mlti_pkg::CFG_COMPS: comps_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (acc_in) begin
						res_value_q <= '0;
						axis_q      <= axis_sel;
						comp_q      <= component;
						case (req_type)
							mlti_pkg::REQ_BP_WR: begin
								res_status_q <= mlti_pkg::ST_RANGE;
								st_q         <= bp_ok ? ST_BPW : ST_FIN;
							end
							mlti_pkg::REQ_TBL_WR: begin
								res_status_q <= tbl_ok ? mlti_pkg::ST_OK : mlti_pkg::ST_RANGE;
								st_q         <= ST_FIN;
							end
							mlti_pkg::REQ_QUERY: begin
								if (32'(size_w) > MAX_TABLE_ENTRIES) begin
									res_status_q <= mlti_pkg::ST_TOOBIG;
									st_q         <= ST_FIN;
								end else if (!q_ok) begin
									res_status_q <= mlti_pkg::ST_RANGE;
									st_q         <= ST_FIN;
								end else begin
									res_status_q <= mlti_pkg::ST_OK;
									st_q         <= ST_QLN;
								end
							end
							default: begin
								res_status_q <= mlti_pkg::ST_RANGE;
								st_q         <= ST_FIN;
							end
						endcase
					end
				end
				ST_BPW: begin
					if (!lres[axis_q].busy) begin
						res_status_q <= lres[axis_q].mono_bad ? mlti_pkg::ST_MONO : mlti_pkg::ST_OK;
						st_q         <= ST_FIN;
					end
				end
				ST_QLN: begin
					if (c_start)
						st_q <= ST_QCN;
				end
				ST_QCN: begin
					if (!c_busy) begin
						res_value_q <= c_value;
						st_q        <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= res_value_q;
						out_status_q <= res_status_q;
						st_q         <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign interp_value = out_value_q;
	assign status       = out_status_q;

	`MLTI_AST_IMP(a_ready_quiet, in_ready, (lbusy == '0) && !c_busy, "ready while a unit is busy")
	`MLTI_AST_IMP(a_start_quiet, c_start, lbusy == '0, "corner walk started with a lane busy")
	`MLTI_AST_NXT(a_fin_load, (st_q == ST_FIN) && (!out_valid_q || out_ready), out_valid_q,
		"finished word not loaded")
	`MLTI_AST_IMP(a_err_zero, out_valid_q && (out_status_q != mlti_pkg::ST_OK), out_value_q == 0,
		"nonzero value with error status")

endmodule
